@@ src/multi_slot_repeat_timer_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Shared property shorthands for the timer table checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_REPEAT_TIMER_TABLE_TOP_DEFINES_SVH
`define MULTI_SLOT_REPEAT_TIMER_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define MSTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mstt_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer table package
// Beat types, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mstt_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int EV_CNT_W    = $clog2(MAX_RESULTS + 1);
	localparam int DIV_W       = 33;

	typedef enum logic [1:0] {
		OP_SET      = 2'd0,
		OP_KILL     = 2'd1,
		OP_KILL_ALL = 2'd2,
		OP_TICK     = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ZERO_REPEAT = 2'd1,
		ST_FULL        = 2'd2,
		ST_NOT_FOUND   = 2'd3
	} status_e_t;

	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_EVENT  = 1'b1
	} kind_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_COMMIT,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] timer_id;
		logic [31:0] elapse_ms;
		logic [31:0] repeat_count;
		logic [31:0] bound_param;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  status;
		logic [31:0] fired_id;
		logic [31:0] fired_param;
		logic        last;
	} result_t;

	typedef struct packed {
		logic load;
		logic walk_rd;
		logic commit;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_last;
		logic is_tick;
		logic commit_ready;
	} dp_sts_t;

endpackage

@@ src/multi_slot_repeat_timer_table_top.sv @@
// ----------------------------------------------------------------------------
// Multi-slot repeating timer table
// Timer slots with set, kill, kill-all and tick; expiry events per tick.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the item is done. Every item walks the slots one per cycle through a
// single memory read port. A set also rounds the elapse up to ticks in a
// reciprocal multiply that runs beside the walk, and its commit waits for
// the quotient. Set, kill and kill-all give one status beat, with last set,
// in the cycle busy falls. A tick gives one event beat per firing slot in
// slot order (at most 16), the final one with last set as busy falls, and
// no beat at all when nothing fires. Beats are shown for one cycle with
// result_valid and cannot be held off. Write the forever-repeat code only
// while busy is low.
`include "multi_slot_repeat_timer_table_top_defines.svh"

module multi_slot_repeat_timer_table_top #(
	parameter int TIMER_SLOTS = 16,
	parameter int TICK_MS     = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mstt_pkg::item_t   item,
	output logic              result_valid,
	output mstt_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata
);
	import mstt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	mstt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	mstt_dp #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.TICK_MS     (TICK_MS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

	`MSTT_ASSERT_IMP(a_last_at_done, clk, arst_n, result_valid, result.last == !busy, "last flag disagrees with busy")
	`MSTT_ASSERT_IMP(a_status_is_last, clk, arst_n, result_valid && result.result_kind == KIND_STATUS, result.last, "status beat without last")
	`MSTT_ASSERT_IMP(a_beat_from_work, clk, arst_n, result_valid, $past(busy), "beat without an item in flight")
	`MSTT_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted item did not raise busy")

endmodule

@@ src/mstt_div.sv @@
// ----------------------------------------------------------------------------
// Timer table tick divider
// Reciprocal multiply by a fixed divisor: operand, two partial products, sum.
// The quotient register and done are loaded together from the sum.
// ----------------------------------------------------------------------------
module mstt_div #(
	parameter int DIVISOR = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mstt_pkg::DIV_W-1:0] dividend,
	output logic [mstt_pkg::DIV_W-1:0] quotient,
	output logic                       done
);
	import mstt_pkg::*;

	// floor(x / DIVISOR) == (x * RECIP) >> SHIFT for every DIV_W-bit x
	localparam int L_W   = $clog2(DIVISOR);
	localparam int SHIFT = DIV_W + L_W;
	localparam int R_W   = DIV_W + 1;
	localparam int H_W   = R_W / 2;
	localparam int PP_W  = DIV_W + H_W;
	localparam int P_W   = DIV_W + SHIFT;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [R_W-1:0] RECIP    = R_W'(RECIP_FULL);
	localparam logic [H_W-1:0] RECIP_LO = RECIP[H_W-1:0];
	localparam logic [H_W-1:0] RECIP_HI = RECIP[R_W-1:H_W];

	logic [DIV_W-1:0] x_s1;
	logic             vld_s1;
	logic             vld_s2;
	logic [PP_W-1:0]  prod_lo_s2;
	logic [PP_W-1:0]  prod_hi_s2;
	logic [P_W-1:0]   prod_sum;
	logic [DIV_W-1:0] quot_q;
	logic             done_q;

	assign prod_sum = P_W'(prod_lo_s2) + (P_W'(prod_hi_s2) << H_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			if (start)
				done_q <= 1'b0;
			else if (vld_s2)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			x_s1 <= dividend;
		if (vld_s1) begin
			prod_lo_s2 <= PP_W'(x_s1) * PP_W'(RECIP_LO);
			prod_hi_s2 <= PP_W'(x_s1) * PP_W'(RECIP_HI);
		end
		if (vld_s2)
			quot_q <= prod_sum[SHIFT +: DIV_W];
	end

	assign quotient = quot_q;
	assign done     = done_q;

endmodule

@@ src/mstt_dp.sv @@
// ----------------------------------------------------------------------------
// Timer table datapath
// Slot memories, valid bits, slot walk, search, tick countdown and the
// result register.
// ----------------------------------------------------------------------------
module mstt_dp #(
	parameter int TIMER_SLOTS = 16,
	parameter int TICK_MS     = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mstt_pkg::item_t   item,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  mstt_pkg::dp_cmd_t cmd,
	output mstt_pkg::dp_sts_t sts,
	output logic              result_valid,
	output mstt_pkg::result_t result
);
	import mstt_pkg::*;

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	logic [31:0] id_mem    [TIMER_SLOTS];
	logic [31:0] param_mem [TIMER_SLOTS];
	logic [31:0] per_mem   [TIMER_SLOTS];
	logic [31:0] rem_mem   [TIMER_SLOTS];
	logic [31:0] rep_mem   [TIMER_SLOTS];

	logic [TIMER_SLOTS-1:0] valid_q;
	logic [31:0]            forever_q;
	item_t                  item_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_s1;
	logic          rd_vld_s1;
	logic [31:0]   id_s1, param_s1, per_s1, rem_s1, rep_s1;

	logic          match_q, free_q;
	logic [IW-1:0] match_idx_q, free_idx_q;

	logic                pend_vld_q;
	logic [31:0]         pend_id_q, pend_param_q;
	logic [EV_CNT_W-1:0] ev_cnt_q;

	logic          res_vld_q;
	result_t       res_q;

	logic [DIV_W-1:0] dividend, quotient;
	logic             div_done;
	logic [31:0]      ticks;

	logic          is_tick, rep_zero, slot_on, tick_act, fire, counts, retire, capture;
	logic          set_wr, kill_wr;
	logic [IW-1:0] tgt;
	logic [1:0]    status_code;

	assign dividend = DIV_W'(item.elapse_ms) + DIV_W'(TICK_MS - 1);

	mstt_div #(.DIVISOR(TICK_MS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (dividend),
		.quotient (quotient),
		.done     (div_done)
	);

	// zero elapse still waits one tick
	assign ticks = (quotient == '0) ? 32'd1 : quotient[31:0];

	assign is_tick  = item_q.operation == OP_TICK;
	assign rep_zero = item_q.repeat_count == 32'd0;
	assign slot_on  = rd_vld_s1 && valid_q[idx_s1];
	assign tick_act = slot_on && is_tick;
	assign fire     = tick_act && (rem_s1 <= 32'd1);
	assign counts   = fire && (rep_s1 != forever_q);
	assign retire   = counts && (rep_s1 <= 32'd1);
	assign capture  = fire && (ev_cnt_q < EV_CNT_W'(MAX_RESULTS));
	assign tgt      = match_q ? match_idx_q : free_idx_q;

	always_comb begin
		unique case (item_q.operation)
			OP_SET: begin
				if (rep_zero)
					status_code = ST_ZERO_REPEAT;
				else if (match_q || free_q)
					status_code = ST_OK;
				else
					status_code = ST_FULL;
			end
			OP_KILL:     status_code = match_q ? ST_OK : ST_NOT_FOUND;
			OP_KILL_ALL: status_code = ST_OK;
			default:     status_code = ST_OK;
		endcase
	end

	assign set_wr  = cmd.commit && (item_q.operation == OP_SET) && !rep_zero
		&& (match_q || free_q);
	assign kill_wr = cmd.commit && (item_q.operation == OP_KILL) && match_q;

	assign sts.walk_last    = idx_q == IW'(TIMER_SLOTS - 1);
	assign sts.is_tick      = is_tick;
	assign sts.commit_ready = !((item_q.operation == OP_SET) && !rep_zero && !div_done);

	// configuration and captured item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			forever_q <= 32'hFFFF_FFFF;
		else if (cfg_we)
			forever_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= item;
	end

	// slot walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			idx_s1    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.walk_rd;
			idx_s1    <= idx_q;
			if (cmd.load)
				idx_q <= '0;
			else if (cmd.walk_rd)
				idx_q <= idx_q + 1'b1;
		end
	end

	// slot memories: one read at the walk index, one write
	always_ff @(posedge clk) begin
		if (cmd.walk_rd) begin
			id_s1    <= id_mem[idx_q];
			param_s1 <= param_mem[idx_q];
			per_s1   <= per_mem[idx_q];
			rem_s1   <= rem_mem[idx_q];
			rep_s1   <= rep_mem[idx_q];
		end
		if (set_wr) begin
			id_mem[tgt]    <= item_q.timer_id;
			param_mem[tgt] <= item_q.bound_param;
			per_mem[tgt]   <= ticks;
		end
		if (set_wr)
			rem_mem[tgt] <= ticks;
		else if (tick_act)
			rem_mem[idx_s1] <= fire ? per_s1 : rem_s1 - 32'd1;
		if (set_wr)
			rep_mem[tgt] <= item_q.repeat_count;
		else if (counts && !retire)
			rep_mem[idx_s1] <= rep_s1 - 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.commit && (item_q.operation == OP_KILL_ALL))
				valid_q <= '0;
			else if (set_wr)
				valid_q[tgt] <= 1'b1;
			else if (kill_wr)
				valid_q[match_idx_q] <= 1'b0;
			else if (retire)
				valid_q[idx_s1] <= 1'b0;
		end
	end

	// search: first valid id match, first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			match_idx_q <= '0;
			free_idx_q  <= '0;
		end else if (cmd.load) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (rd_vld_s1 && !is_tick) begin
			if (slot_on && (id_s1 == item_q.timer_id) && !match_q) begin
				match_q     <= 1'b1;
				match_idx_q <= idx_s1;
			end
			if (!valid_q[idx_s1] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
	end

	// expiry events: hold one back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			ev_cnt_q   <= '0;
		end else if (cmd.load) begin
			pend_vld_q <= 1'b0;
			ev_cnt_q   <= '0;
		end else if (capture) begin
			pend_vld_q <= 1'b1;
			ev_cnt_q   <= ev_cnt_q + 1'b1;
		end else if (cmd.flush) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			pend_id_q    <= id_s1;
			pend_param_q <= param_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else
			res_vld_q <= cmd.commit || ((capture || cmd.flush) && pend_vld_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.result_kind <= KIND_STATUS;
			res_q.status      <= status_code;
			res_q.fired_id    <= '0;
			res_q.fired_param <= '0;
			res_q.last        <= 1'b1;
		end else if ((capture || cmd.flush) && pend_vld_q) begin
			res_q.result_kind <= KIND_EVENT;
			res_q.status      <= ST_OK;
			res_q.fired_id    <= pend_id_q;
			res_q.fired_param <= pend_param_q;
			res_q.last        <= cmd.flush;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

@@ src/mstt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Timer table controller
// Sequences the slot walk, the commit of set, kill and kill-all results and
// the flush of the last expiry event.
// ----------------------------------------------------------------------------
module mstt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mstt_pkg::dp_sts_t sts,
	output mstt_pkg::dp_cmd_t cmd,
	output logic              busy
);
	import mstt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (start) state_d = S_WALK;
			S_WALK:   if (sts.walk_last) state_d = S_DRAIN;
			S_DRAIN:  state_d = sts.is_tick ? S_FLUSH : S_COMMIT;
			S_COMMIT: if (sts.commit_ready) state_d = S_IDLE;
			S_FLUSH:  state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_WALK:   cmd.walk_rd = 1'b1;
			S_DRAIN:  ;
			S_COMMIT: cmd.commit = sts.commit_ready;
			S_FLUSH:  cmd.flush = 1'b1;
			default:  ;
		endcase
	end

endmodule
